/* src/bba_pkg.sv */
package bba_pkg;

    localparam int NUM_BLOCKS = 4096;
    localparam int BYTE_BITS  = 8;
    localparam int MAP_BYTES  = (NUM_BLOCKS + BYTE_BITS - 1) / BYTE_BITS;
    localparam int MAP_AW     = $clog2(MAP_BYTES);
    localparam int CNT_W      = $clog2(MAP_BYTES + 1);
    localparam int BLK_W      = 12;
    localparam int CFG_W      = 13;
    localparam int REQ_W      = 2;
    localparam int BIT_W      = $clog2(BYTE_BITS);

    localparam logic [BYTE_BITS-1:0] FULL_BYTE = '1;

    localparam logic [REQ_W-1:0] REQ_MARK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TEST = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIND = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_TEST_RD,
        ST_TEST_EV,
        ST_FIND,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [BLK_W-1:0] block_index;
    } bba_req_t;

    typedef struct packed {
        logic             flag;
        logic [BLK_W-1:0] found_block;
    } bba_res_t;

endpackage

/* src/bba_engine.sv */
module bba_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  bba_pkg::bba_req_t     req,
    input  logic [bba_pkg::CNT_W-1:0] scan_bytes,
    output logic                  res_valid,
    input  logic                  res_ready,
    output bba_pkg::bba_res_t     res
);

    bba_pkg::state_t state_reg, state_next;

    logic [bba_pkg::BYTE_BITS-1:0] mem [bba_pkg::MAP_BYTES];
    logic [bba_pkg::BYTE_BITS-1:0] rd_data_reg;

    logic [bba_pkg::MAP_AW-1:0]    clr_ptr_reg;
    bba_pkg::bba_req_t             req_reg;
    logic [bba_pkg::CNT_W-1:0]     scan_ptr_reg;
    logic                          pend_reg;
    logic [bba_pkg::MAP_AW-1:0]    pend_addr_reg;
    bba_pkg::bba_res_t             res_reg;

    logic                          mem_we;
    logic [bba_pkg::MAP_AW-1:0]    mem_wa;
    logic [bba_pkg::BYTE_BITS-1:0] mem_wd;
    logic                          mem_re;
    logic [bba_pkg::MAP_AW-1:0]    mem_ra;

    logic                          issue;
    logic                          hit;
    logic [bba_pkg::MAP_AW-1:0]    req_byte;
    logic [bba_pkg::BIT_W-1:0]     req_bit;

    function automatic logic [bba_pkg::BIT_W-1:0] low_zero(
        input logic [bba_pkg::BYTE_BITS-1:0] v
    );
        logic [bba_pkg::BIT_W-1:0] idx;
        idx = '0;
        for (int j = bba_pkg::BYTE_BITS - 1; j >= 0; j--) begin
            if (!v[j]) begin
                idx = bba_pkg::BIT_W'(j);
            end
        end
        return idx;
    endfunction

    assign req_byte = req_reg.block_index[bba_pkg::BLK_W-1:bba_pkg::BIT_W];
    assign req_bit  = req_reg.block_index[bba_pkg::BIT_W-1:0];
    assign issue    = (scan_ptr_reg < scan_bytes);
    assign hit      = pend_reg && (rd_data_reg != bba_pkg::FULL_BYTE);

    assign req_ready = (state_reg == bba_pkg::ST_IDLE);
    assign res_valid = (state_reg == bba_pkg::ST_RESULT);
    assign res       = res_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::ST_CLEAR: begin
                if (clr_ptr_reg == bba_pkg::MAP_AW'(bba_pkg::MAP_BYTES - 1)) begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE: begin
                if (req_valid) begin
                    unique case (req.req_type)
                        bba_pkg::REQ_MARK: state_next = bba_pkg::ST_MARK_RD;
                        bba_pkg::REQ_TEST: state_next = bba_pkg::ST_TEST_RD;
                        bba_pkg::REQ_FIND: state_next = bba_pkg::ST_FIND;
                        default:           state_next = bba_pkg::ST_RESULT;
                    endcase
                end
            end
            bba_pkg::ST_MARK_RD: state_next = bba_pkg::ST_MARK_WR;
            bba_pkg::ST_MARK_WR: state_next = bba_pkg::ST_RESULT;
            bba_pkg::ST_TEST_RD: state_next = bba_pkg::ST_TEST_EV;
            bba_pkg::ST_TEST_EV: state_next = bba_pkg::ST_RESULT;
            bba_pkg::ST_FIND: begin
                if (hit || !issue) begin
                    state_next = bba_pkg::ST_RESULT;
                end
            end
            bba_pkg::ST_RESULT: begin
                if (res_ready) begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            default: state_next = bba_pkg::ST_IDLE;
        endcase
    end

    // memory port controls
    always_comb begin
        mem_we = 1'b0;
        mem_wa = req_byte;
        mem_wd = '0;
        mem_re = 1'b0;
        mem_ra = req_byte;
        unique case (state_reg)
            bba_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = clr_ptr_reg;
            end
            bba_pkg::ST_MARK_RD, bba_pkg::ST_TEST_RD: begin
                mem_re = 1'b1;
            end
            bba_pkg::ST_MARK_WR: begin
                mem_we = 1'b1;
                mem_wd = rd_data_reg | (bba_pkg::BYTE_BITS'(1) << req_bit);
            end
            bba_pkg::ST_FIND: begin
                mem_re = issue && !hit;
                mem_ra = scan_ptr_reg[bba_pkg::MAP_AW-1:0];
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bba_pkg::ST_CLEAR;
            clr_ptr_reg <= '0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == bba_pkg::ST_CLEAR) begin
                clr_ptr_reg <= clr_ptr_reg + 1'b1;
            end
            if (state_reg == bba_pkg::ST_IDLE) begin
                pend_reg <= 1'b0;
            end else if (state_reg == bba_pkg::ST_FIND && issue && !hit) begin
                pend_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            bba_pkg::ST_IDLE: begin
                if (req_valid) begin
                    req_reg      <= req;
                    scan_ptr_reg <= '0;
                    res_reg      <= '0;
                end
            end
            bba_pkg::ST_TEST_EV: begin
                res_reg.flag <= rd_data_reg[req_bit];
            end
            bba_pkg::ST_FIND: begin
                if (hit) begin
                    res_reg.flag        <= 1'b1;
                    res_reg.found_block <= {pend_addr_reg, low_zero(rd_data_reg)};
                end else if (issue) begin
                    // advance one byte; evaluate it next cycle
                    pend_addr_reg <= scan_ptr_reg[bba_pkg::MAP_AW-1:0];
                    scan_ptr_reg  <= scan_ptr_reg + 1'b1;
                end
            end
            default: begin
                res_reg <= res_reg;
            end
        endcase
    end

endmodule

/* src/bitmap_block_allocator_unit.sv */
// Bitmap block allocator: keeps one used bit per block for 4096 blocks in a
// 512 x 8 store with one read and one write port. A request marks a block
// used, tests a block, or finds the lowest free block among the first
// blocks_in_use blocks (whole bytes only, saturating at 4096). One request
// is handled at a time: mark reads a byte and writes it back, test reads
// a byte and evaluates the bit, and the next request can be taken once
// the result moves into the output register. A find reads one bitmap byte
// per cycle through the store's read port and stops at the first non-full
// byte or at the end of the search range (at most 512 bytes, none for an
// empty search range). After reset the store is cleared one byte per cycle,
// a pass over all 512 bytes during which s_tready stays low. Results sit in
// an output register, so a new request can be taken while a result waits.
module bitmap_block_allocator_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,   // [11:0] block_index
    input  logic [1:0]                s_tuser,   // [1:0] req_type
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [15:0]               m_tdata,   // [11:0] found_block
    output logic                      m_tuser,   // [0] flag
    input  logic                      cfg_we,
    input  logic [bba_pkg::CFG_W-1:0] cfg_wdata  // blocks_in_use
);

    logic [bba_pkg::CFG_W-1:0] blocks_in_use_reg;
    logic [bba_pkg::CNT_W-1:0] scan_bytes;

    bba_pkg::bba_req_t req;
    bba_pkg::bba_res_t res;
    logic              res_valid;
    logic              res_ready;

    logic              m_valid_reg;
    bba_pkg::bba_res_t m_res_reg;

    assign req.req_type    = s_tuser;
    assign req.block_index = s_tdata[bba_pkg::BLK_W-1:0];

    assign scan_bytes = (blocks_in_use_reg >= bba_pkg::CFG_W'(bba_pkg::NUM_BLOCKS))
                      ? bba_pkg::CNT_W'(bba_pkg::MAP_BYTES)
                      : bba_pkg::CNT_W'(blocks_in_use_reg >> bba_pkg::BIT_W);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocks_in_use_reg <= bba_pkg::CFG_W'(bba_pkg::NUM_BLOCKS);
        end else if (cfg_we) begin
            blocks_in_use_reg <= cfg_wdata;
        end
    end

    bba_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req        (req),
        .scan_bytes (scan_bytes),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // load the output register when it is empty or its transfer completes
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.flag;
    assign m_tdata  = {{(16 - bba_pkg::BLK_W){1'b0}}, m_res_reg.found_block};

endmodule

/* src/bba_checker.sv */
module bba_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // reset empties the output and starts the clearing pass
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("not quiet after reset");

    // only a successful find reports a nonzero block
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[11:0] != 12'd0) |-> m_tuser)
        else $error("block reported without flag");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
